FILE: hw/rtl/cevpo_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturating helpers for the CEV path/payoff block.
// No dependencies.
package cevpo_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int PRICE_WIDTH_DEF  = 48;

  localparam int SAMPLE_FRAC = 12;
  localparam int COEF_FRAC   = 30;
  localparam int PRICE_FRAC  = 24;

  localparam int PRICE_FIELD_W = 47;
  localparam int TOTAL_W       = 63;
  localparam int OUT_TDATA_W   = 176;  // 47 + 63 + 63 packed, padded to bytes
  localparam int CFG_DATA_W    = 47;
  localparam int CFG_INDEX_W   = 3;

  localparam logic signed [63:0] INT64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] INT64_MIN = {1'b1, {63{1'b0}}};

  typedef enum logic [1:0] {
    SH_SAMPLE,
    SH_PRICE,
    SH_COEF
  } shift_sel_t;

  typedef struct packed {
    logic [63:0] a_mag;
    logic [63:0] b_mag;
    logic        neg;
    shift_sel_t  sh;
  } mul_req_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic mul_req_t mk_req(input logic signed [63:0] x,
                                      input logic signed [63:0] y,
                                      input shift_sel_t sh);
    mul_req_t r;
    r.a_mag = mag64(x);
    r.b_mag = mag64(y);
    r.neg   = x[63] ^ y[63];
    r.sh    = sh;
    mk_req  = r;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add64 = s[64] ? INT64_MIN : INT64_MAX;
    end else begin
      sat_add64 = s[63:0];
    end
  endfunction

endpackage

FILE: hw/rtl/cevpo_mul.sv
`timescale 1ns / 1ps
// Shared sign-magnitude multiplier: 64x64, 16 bits of B per cycle, then a
// fixed-point right shift and saturation to int64. Uses cevpo_pkg.
module cevpo_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  cevpo_pkg::mul_req_t req,
  output logic                done,
  output logic signed [63:0]  result
);

  localparam int CHUNK   = 16;
  localparam int NCHUNKS = 64 / CHUNK;

  logic [63:0]  a;
  logic [63:0]  b;
  logic [127:0] acc;
  logic [2:0]   cnt;
  logic         busy;
  logic         neg;
  cevpo_pkg::shift_sel_t sh;

  logic [79:0]  part;
  logic [127:0] shifted;
  logic [62:0]  mag;

  assign part = a * b[63 -: CHUNK];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a    <= req.a_mag;
        b    <= req.b_mag;
        neg  <= req.neg;
        sh   <= req.sh;
        acc  <= '0;
        cnt  <= 3'(NCHUNKS);
        busy <= 1'b1;
      end else if (busy) begin
        // MSB chunk first: shift the partial sum up, add the next row
        acc <= (acc << CHUNK) + {48'd0, part};
        b   <= b << CHUNK;
        cnt <= cnt - 3'd1;
        if (cnt == 3'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    case (sh)
      cevpo_pkg::SH_SAMPLE: shifted = acc >> cevpo_pkg::SAMPLE_FRAC;
      cevpo_pkg::SH_PRICE:  shifted = acc >> cevpo_pkg::PRICE_FRAC;
      cevpo_pkg::SH_COEF:   shifted = acc >> cevpo_pkg::COEF_FRAC;
      default:              shifted = acc >> cevpo_pkg::COEF_FRAC;
    endcase
    mag    = (|shifted[127:63]) ? {63{1'b1}} : shifted[62:0];
    result = neg ? (64'sd0 - {1'b0, mag}) : {1'b0, mag};
  end

endmodule

FILE: hw/rtl/cevpo_sqrt.sv
`timescale 1ns / 1ps
// Restoring digit-by-digit square root, one root bit per cycle.
// No package dependencies.
module cevpo_sqrt #(
  parameter int IN_WIDTH = 72
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [IN_WIDTH-1:0]   radicand,
  output logic                  done,
  output logic [IN_WIDTH/2-1:0] root
);

  localparam int ITERS = IN_WIDTH / 2;
  localparam int CW    = $clog2(ITERS + 1);

  logic [IN_WIDTH-1:0] rad;
  logic [ITERS+2:0]    rem;
  logic [CW-1:0]       cnt;
  logic                busy;

  logic [ITERS+2:0] rem_t;
  logic [ITERS+2:0] trial;

  assign rem_t = {rem[ITERS:0], rad[IN_WIDTH-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= CW'(ITERS);
        busy <= 1'b1;
      end else if (busy) begin
        rad <= rad << 2;
        if (rem_t >= trial) begin
          rem  <= rem_t - trial;
          root <= {root[ITERS-2:0], 1'b1};
        end else begin
          rem  <= rem_t;
          root <= {root[ITERS-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/cev_path_option_payoff_accumulator.sv
`timescale 1ns / 1ps
// CEV Euler-Maruyama path stepper with call/put payoff accumulation.
// Uses cevpo_pkg, cevpo_mul, cevpo_sqrt.
//
// Usage: each input word on s_* is one standard-normal sample (Q4.12) and
// advances the path price by one step. After steps_per_path words the path
// ends and one output word leaves on m_*: payoff and running sums of payoff
// and squared payoff; m_tlast marks the last path of a run, after which the
// sums and path count clear. Other samples give no output word.
// Flow control: one sample at a time, s_tready is high only while idle. All
// products go through one 64x16-per-cycle multiplier, three per step and a
// fourth for beta 2; for beta 0.5 the bit-serial square root adds one root
// bit per cycle (PRICE_WIDTH/2+12 bits).
// A path end adds the payoff square, through the same multiplier, and the sums.
// The output register holds a word until m_tready; the sequencer waits
// there only if a new path end arrives before the old word is taken.
// Reset (rst, synchronous) sets the configuration to defaults, clears sums,
// counters and m_tvalid; the first step of every path loads spot_price.
// Configuration: cfg_we/cfg_index/cfg_data, to be written by the user only
// while idle; the block itself does not enforce it.
module cev_path_option_payoff_accumulator #(
  parameter int SAMPLE_WIDTH = cevpo_pkg::SAMPLE_WIDTH_DEF,
  parameter int PRICE_WIDTH  = cevpo_pkg::PRICE_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,

  input  logic                                 cfg_we,
  input  logic [cevpo_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cevpo_pkg::CFG_DATA_W-1:0]     cfg_data,

  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,  // normal_sample

  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // path_payoff[46:0], payoff_total[109:47], squared_total[172:110], pad
  output logic [cevpo_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                 m_tlast   // run_done
);

  localparam logic [cevpo_pkg::CFG_INDEX_W-1:0] REG_SPOT   = 3'd0;
  localparam logic [cevpo_pkg::CFG_INDEX_W-1:0] REG_STRIKE = 3'd1;
  localparam logic [cevpo_pkg::CFG_INDEX_W-1:0] REG_PUT    = 3'd2;
  localparam logic [cevpo_pkg::CFG_INDEX_W-1:0] REG_BETA   = 3'd3;
  localparam logic [cevpo_pkg::CFG_INDEX_W-1:0] REG_DRIFT  = 3'd4;
  localparam logic [cevpo_pkg::CFG_INDEX_W-1:0] REG_DIFF   = 3'd5;
  localparam logic [cevpo_pkg::CFG_INDEX_W-1:0] REG_STEPS  = 3'd6;
  localparam logic [cevpo_pkg::CFG_INDEX_W-1:0] REG_PATHS  = 3'd7;

  localparam logic [1:0] BETA_SQRT = 2'd1;
  localparam logic [1:0] BETA_SQR  = 2'd2;

  localparam int VB      = (PRICE_WIDTH > 48) ? PRICE_WIDTH : 48;
  localparam int SQ_IN   = ((VB + cevpo_pkg::PRICE_FRAC + 1) / 2) * 2;
  localparam int SQ_ROOT = SQ_IN / 2;

  localparam logic signed [63:0] PMAX = (64'sd1 <<< (PRICE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] PMIN = -PMAX - 64'sd1;
  localparam logic signed [65:0] PAYOFF_MAX = 66'sd140737488355327;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DRIFT, ST_DRIFT_W, ST_FUNC, ST_FUNC_W, ST_GAIN, ST_GAIN_W,
    ST_WIENER, ST_WIENER_W, ST_SUM1, ST_SUM2, ST_PAY, ST_SQ, ST_SQ_W, ST_ACC,
    ST_OUT
  } state_t;

  // configuration
  logic [46:0] spot_price;
  logic [46:0] strike_price;
  logic        is_put;
  logic [1:0]  beta_mode;
  logic [31:0] drift_per_step;
  logic [31:0] diffusion_per_step;
  logic [15:0] steps_per_path;
  logic [31:0] path_total;

  // path state
  state_t                  state;
  logic [PRICE_WIDTH-1:0]  path_price;
  logic [15:0]             step_index;
  logic [31:0]             path_index;
  logic [62:0]             payoff_acc;
  logic [62:0]             square_acc;

  // working registers
  logic signed [63:0] z;
  logic signed [63:0] s;
  logic signed [63:0] dterm;
  logic signed [63:0] f;
  logic signed [63:0] g;
  logic signed [63:0] w;
  logic signed [63:0] t;
  logic [46:0]        payoff;
  logic signed [63:0] sq;
  logic [62:0]        pay_sum;
  logic [62:0]        sq_sum;
  logic               last;

  // shared units
  logic                    mul_start;
  cevpo_pkg::mul_req_t     mul_req;
  logic                    mul_done;
  logic signed [63:0]      mul_res;
  logic                    sq_start;
  logic                    sq_done;
  logic [SQ_ROOT-1:0]      sq_root;
  logic [SQ_IN-1:0]        radicand;

  cevpo_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .req    (mul_req),
    .done   (mul_done),
    .result (mul_res)
  );

  cevpo_sqrt #(.IN_WIDTH(SQ_IN)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (radicand),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign radicand = SQ_IN'({s[VB-1:0], {cevpo_pkg::PRICE_FRAC{1'b0}}});
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    mul_start = 1'b0;
    sq_start  = 1'b0;
    mul_req   = cevpo_pkg::mk_req({{32{drift_per_step[31]}}, drift_per_step}, s,
                                  cevpo_pkg::SH_COEF);
    case (state)
      ST_DRIFT: mul_start = 1'b1;
      ST_FUNC: begin
        mul_req = cevpo_pkg::mk_req(s, s, cevpo_pkg::SH_PRICE);
        if (beta_mode == BETA_SQR) begin
          mul_start = 1'b1;
        end else if (beta_mode == BETA_SQRT && s > 64'sd0) begin
          sq_start = 1'b1;
        end
      end
      ST_GAIN: begin
        mul_req   = cevpo_pkg::mk_req(f,
                      {{32{diffusion_per_step[31]}}, diffusion_per_step},
                      cevpo_pkg::SH_COEF);
        mul_start = 1'b1;
      end
      ST_WIENER: begin
        mul_req   = cevpo_pkg::mk_req(g, z, cevpo_pkg::SH_SAMPLE);
        mul_start = 1'b1;
      end
      ST_SQ: begin
        mul_req   = cevpo_pkg::mk_req({17'd0, payoff}, {17'd0, payoff},
                                      cevpo_pkg::SH_PRICE);
        mul_start = 1'b1;
      end
      default: ;
    endcase
  end

  // combinational helpers for the sum/payoff states
  logic signed [63:0] price_sum;
  logic signed [63:0] price_clamped;
  logic [15:0]        step_inc;
  logic [15:0]        steps_eff;
  logic [31:0]        path_inc;
  logic [31:0]        paths_eff;
  logic signed [65:0] pv;
  logic [63:0]        pay_wide;
  logic [63:0]        sq_wide;

  always_comb begin
    price_sum     = cevpo_pkg::sat_add64(t, w);
    price_clamped = (price_sum > PMAX) ? PMAX : ((price_sum < PMIN) ? PMIN : price_sum);
    step_inc      = step_index + 16'd1;
    steps_eff     = (steps_per_path == 16'd0) ? 16'd1 : steps_per_path;
    path_inc      = path_index + 32'd1;
    paths_eff     = (path_total == 32'd0) ? 32'd1 : path_total;
    pv = is_put ? ({19'd0, strike_price} - {{2{s[63]}}, s})
                : ({{2{s[63]}}, s} - {19'd0, strike_price});
    pay_wide = {1'b0, payoff_acc} + {17'd0, payoff};
    sq_wide  = {1'b0, square_acc} + sq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spot_price         <= '0;
      strike_price       <= '0;
      is_put             <= 1'b0;
      beta_mode          <= '0;
      drift_per_step     <= '0;
      diffusion_per_step <= '0;
      steps_per_path     <= 16'd1;
      path_total         <= 32'd1;
      state              <= ST_IDLE;
      step_index         <= '0;
      path_index         <= '0;
      payoff_acc         <= '0;
      square_acc         <= '0;
      m_tvalid           <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SPOT:   spot_price         <= cfg_data;
          REG_STRIKE: strike_price       <= cfg_data;
          REG_PUT:    is_put             <= cfg_data[0];
          REG_BETA:   beta_mode          <= cfg_data[1:0];
          REG_DRIFT:  drift_per_step     <= cfg_data[31:0];
          REG_DIFF:   diffusion_per_step <= cfg_data[31:0];
          REG_STEPS:  steps_per_path     <= cfg_data[15:0];
          REG_PATHS:  path_total         <= cfg_data[31:0];
          default: ;
        endcase
      end

      // ST_OUT reloads the output register itself
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            z <= {{(64-SAMPLE_WIDTH){s_tdata[SAMPLE_WIDTH-1]}},
                  s_tdata[SAMPLE_WIDTH-1:0]};
            // first step of a path starts from spot
            s <= (step_index == 16'd0) ? {17'd0, spot_price}
                 : {{(64-PRICE_WIDTH){path_price[PRICE_WIDTH-1]}}, path_price};
            state <= ST_DRIFT;
          end
        end
        ST_DRIFT: state <= ST_DRIFT_W;
        ST_DRIFT_W: begin
          if (mul_done) begin
            dterm <= mul_res;
            state <= ST_FUNC;
          end
        end
        ST_FUNC: begin
          if (beta_mode == BETA_SQR) begin
            state <= ST_FUNC_W;
          end else if (beta_mode == BETA_SQRT) begin
            if (s > 64'sd0) begin
              state <= ST_FUNC_W;
            end else begin
              f     <= '0;
              state <= ST_GAIN;
            end
          end else begin
            f     <= s;
            state <= ST_GAIN;
          end
        end
        ST_FUNC_W: begin
          if (mul_done) begin
            f     <= mul_res;
            state <= ST_GAIN;
          end else if (sq_done) begin
            f     <= 64'(sq_root);
            state <= ST_GAIN;
          end
        end
        ST_GAIN: state <= ST_GAIN_W;
        ST_GAIN_W: begin
          if (mul_done) begin
            g     <= mul_res;
            state <= ST_WIENER;
          end
        end
        ST_WIENER: state <= ST_WIENER_W;
        ST_WIENER_W: begin
          if (mul_done) begin
            w     <= mul_res;
            state <= ST_SUM1;
          end
        end
        ST_SUM1: begin
          t     <= cevpo_pkg::sat_add64(s, dterm);
          state <= ST_SUM2;
        end
        ST_SUM2: begin
          path_price <= price_clamped[PRICE_WIDTH-1:0];
          s          <= price_clamped;
          if (step_inc < steps_eff && step_inc != 16'd0) begin
            step_index <= step_inc;
            state      <= ST_IDLE;
          end else begin
            step_index <= '0;
            state      <= ST_PAY;
          end
        end
        ST_PAY: begin
          if (pv <= 66'sd0) begin
            payoff <= '0;
          end else if (pv > PAYOFF_MAX) begin
            payoff <= '1;
          end else begin
            payoff <= pv[46:0];
          end
          state <= ST_SQ;
        end
        ST_SQ: state <= ST_SQ_W;
        ST_SQ_W: begin
          if (mul_done) begin
            sq    <= mul_res;
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          pay_sum <= pay_wide[63] ? '1 : pay_wide[62:0];
          sq_sum  <= sq_wide[63] ? '1 : sq_wide[62:0];
          last    <= (path_inc >= paths_eff) || (path_inc == 32'd0);
          state   <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'd0, sq_sum, pay_sum, payoff};
            m_tlast  <= last;
            if (last) begin
              path_index <= '0;
              payoff_acc <= '0;
              square_acc <= '0;
            end else begin
              path_index <= path_inc;
              payoff_acc <= pay_sum;
              square_acc <= sq_sum;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: verif/cev_tb_pkg.sv
`timescale 1ns / 1ps
// Register indexes, beta codes and the payoff word type shared by the testbench files.
// No dependencies.
package cev_tb_pkg;

  typedef enum logic [2:0] {
    REG_SPOT   = 3'd0,
    REG_STRIKE = 3'd1,
    REG_IS_PUT = 3'd2,
    REG_BETA   = 3'd3,
    REG_DRIFT  = 3'd4,
    REG_DIFF   = 3'd5,
    REG_STEPS  = 3'd6,
    REG_PATHS  = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BETA_ONE    = 2'd0,
    BETA_SQRT   = 2'd1,
    BETA_SQUARE = 2'd2,
    BETA_CODE3  = 2'd3
  } beta_e;

  typedef struct packed {
    logic [46:0] payoff;
    logic [62:0] payoff_sum;
    logic [62:0] square_sum;
    logic        last_path;
  } payoff_word_t;

endpackage

FILE: verif/cev_path_checker.sv
`timescale 1ns / 1ps
// Payoff predictor and scoreboard for the CEV path block: follows config writes,
// predicts a payoff word per completed path and compares m_* words. Uses cev_tb_pkg.
module cev_path_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [46:0]  cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [15:0]  s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [175:0] m_tdata,
  input  logic         m_tlast,
  output int           fail_count,
  output int           pending
);

  localparam logic signed [63:0] I64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] I64_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [63:0] PRICE_HI = (64'sd1 <<< 47) - 1;
  localparam logic signed [63:0] PRICE_LO = -(64'sd1 <<< 47);
  localparam logic [63:0] PAYOFF_CAP = (64'd1 << 47) - 1;
  localparam logic [63:0] SUM_CAP = {1'b0, {63{1'b1}}};

  logic [46:0] spot, strike;
  logic        put_sel;
  logic [1:0]  beta;
  logic signed [31:0] drift, diffusion;
  logic [15:0] steps;
  logic [31:0] paths;

  logic signed [63:0] price;
  logic [15:0] step_idx;
  logic [31:0] path_idx;
  logic [63:0] payoff_acc, square_acc;

  cev_tb_pkg::payoff_word_t payoff_q[$];

  assign pending = payoff_q.size();

  // exact product, >> sh, truncated toward zero, saturated to int64
  function automatic logic signed [63:0] mul_trunc(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input int sh);
    logic [127:0] p;
    logic [63:0] ma, mb;
    logic neg;
    ma = a[63] ? 64'd0 - a : a;
    mb = b[63] ? 64'd0 - b : b;
    neg = a[63] ^ b[63];
    p = {64'd0, ma} * {64'd0, mb};
    p = p >> sh;
    if (p[127:63] != 0) return neg ? -I64_MAX : I64_MAX;
    return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? I64_MIN : I64_MAX;
    return s[63:0];
  endfunction

  // floor(sqrt(v << 24))
  function automatic logic signed [63:0] root_q24(input logic signed [63:0] v);
    logic [127:0] x, rem, root, trial;
    x = {64'd0, v} << 24;
    rem = 0;
    root = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | x[2*i +: 2];
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root[63:0];
  endfunction

  function automatic logic [63:0] sum_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, SUM_CAP}) ? SUM_CAP : s[63:0];
  endfunction

  task automatic advance_path(input logic signed [15:0] z);
    logic signed [63:0] s, f, dterm, wterm, nxt, pv;
    logic [15:0] steps_eff;
    logic [31:0] paths_eff;
    logic [63:0] pay, sq;
    cev_tb_pkg::payoff_word_t w;
    steps_eff = (steps == 0) ? 16'd1 : steps;
    paths_eff = (paths == 0) ? 32'd1 : paths;
    if (step_idx == 0) price = {17'd0, spot};
    s = price;
    case (beta)
      cev_tb_pkg::BETA_SQRT:   f = (s > 0) ? root_q24(s) : 64'sd0;
      cev_tb_pkg::BETA_SQUARE: f = mul_trunc(s, s, 24);
      default:                 f = s;
    endcase
    dterm = mul_trunc(drift, s, 30);
    wterm = mul_trunc(mul_trunc(f, diffusion, 30), z, 12);
    nxt = add_sat(add_sat(s, dterm), wterm);
    price = (nxt > PRICE_HI) ? PRICE_HI : ((nxt < PRICE_LO) ? PRICE_LO : nxt);
    step_idx = step_idx + 16'd1;
    if (step_idx < steps_eff && step_idx != 0) return;
    step_idx = 0;
    pv = put_sel ? add_sat({17'd0, strike}, -price) : add_sat(price, -{17'd0, strike});
    pay = (pv <= 0) ? 64'd0 : (($unsigned(pv) > PAYOFF_CAP) ? PAYOFF_CAP : pv);
    sq = mul_trunc(pay, pay, 24);
    payoff_acc = sum_sat(payoff_acc, pay);
    square_acc = sum_sat(square_acc, sq);
    path_idx = path_idx + 32'd1;
    w.payoff = pay[46:0];
    w.payoff_sum = payoff_acc[62:0];
    w.square_sum = square_acc[62:0];
    w.last_path = (path_idx >= paths_eff) || (path_idx == 0);
    payoff_q.push_back(w);
    if (w.last_path) begin
      path_idx = 0;
      payoff_acc = 0;
      square_acc = 0;
    end
    price = {17'd0, spot};
  endtask

  always @(posedge clk) begin
    cev_tb_pkg::payoff_word_t exp_w, got_w;
    if (rst) begin
      spot = 0; strike = 0; put_sel = 0; beta = cev_tb_pkg::BETA_ONE;
      drift = 0; diffusion = 0; steps = 1; paths = 1;
      price = 0; step_idx = 0; path_idx = 0; payoff_acc = 0; square_acc = 0;
      payoff_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cev_tb_pkg::cfg_reg_e'(cfg_index))
          cev_tb_pkg::REG_SPOT:   spot = cfg_data;
          cev_tb_pkg::REG_STRIKE: strike = cfg_data;
          cev_tb_pkg::REG_IS_PUT: put_sel = cfg_data[0];
          cev_tb_pkg::REG_BETA:   beta = cfg_data[1:0];
          cev_tb_pkg::REG_DRIFT:  drift = cfg_data[31:0];
          cev_tb_pkg::REG_DIFF:   diffusion = cfg_data[31:0];
          cev_tb_pkg::REG_STEPS:  steps = cfg_data[15:0];
          cev_tb_pkg::REG_PATHS:  paths = cfg_data[31:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got_w.payoff = m_tdata[46:0];
        got_w.payoff_sum = m_tdata[109:47];
        got_w.square_sum = m_tdata[172:110];
        got_w.last_path = m_tlast;
        if (payoff_q.size() == 0) begin
          $display("%0t: unexpected word payoff=%h sum=%h sq=%h last=%b", $time,
                   got_w.payoff, got_w.payoff_sum, got_w.square_sum, got_w.last_path);
          fail_count++;
        end else begin
          exp_w = payoff_q.pop_front();
          if (got_w.payoff !== exp_w.payoff) begin
            $display("%0t: payoff exp %h got %h", $time, exp_w.payoff, got_w.payoff);
            fail_count++;
          end
          if (got_w.payoff_sum !== exp_w.payoff_sum) begin
            $display("%0t: payoff sum exp %h got %h", $time, exp_w.payoff_sum,
                     got_w.payoff_sum);
            fail_count++;
          end
          if (got_w.square_sum !== exp_w.square_sum) begin
            $display("%0t: square sum exp %h got %h", $time, exp_w.square_sum,
                     got_w.square_sum);
            fail_count++;
          end
          if (got_w.last_path !== exp_w.last_path) begin
            $display("%0t: last exp %b got %b", $time, exp_w.last_path, got_w.last_path);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) advance_path(s_tdata);
    end
  end

endmodule

FILE: verif/cev_path_option_payoff_accumulator_tb.sv
`timescale 1ns / 1ps
// Top of the CEV path block testbench: clock, reset, config, sample stimulus
// and the verdict. Uses cev_tb_pkg, cev_path_checker and the block's RTL.
module cev_path_option_payoff_accumulator_tb;

  localparam int WATCHDOG = 20000;
  localparam logic [46:0] ONE_Q24 = 47'd1 << 24;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [46:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [175:0] m_tdata;
  logic m_tlast;
  int fail_count, pending;
  int tx_idle = 0, rx_idle = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  cev_path_option_payoff_accumulator dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  cev_path_checker chk (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  always @(negedge clk) m_tready <= ($urandom_range(99) >= rx_idle);

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic write_reg(input cev_tb_pkg::cfg_reg_e idx, input logic [46:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // s_tready only moves at rising edges, so it is checked between edges
  task automatic send_sample(input logic [15:0] z);
    while ($urandom_range(99) < tx_idle) @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = z;
    while (!s_tready) @(negedge clk);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // let all payoff words arrive, then give the block time to finish any step
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  function automatic logic [46:0] near_hundred();
    return 47'((47'd100 << 24) + 47'($urandom_range(0, 40 << 24)) - (47'd20 << 24));
  endfunction

  task automatic random_setup();
    logic [46:0] spot_v;
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       spot_v = rnd[46:0];
      1:       spot_v = {47{1'b1}};
      2:       spot_v = '0;
      default: spot_v = near_hundred();
    endcase
    write_reg(cev_tb_pkg::REG_SPOT, spot_v);
    rnd = {$urandom, $urandom};
    write_reg(cev_tb_pkg::REG_STRIKE, ($urandom_range(7) == 0) ? rnd[46:0]
                                                                : near_hundred());
    write_reg(cev_tb_pkg::REG_IS_PUT, 47'($urandom_range(1)));
    write_reg(cev_tb_pkg::REG_BETA, 47'($urandom_range(3)));
    write_reg(cev_tb_pkg::REG_DRIFT, ($urandom_range(7) == 0) ? {15'd0, $urandom}
              : {15'd0, 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21))});
    write_reg(cev_tb_pkg::REG_DIFF, ($urandom_range(7) == 0) ? {15'd0, $urandom}
              : {15'd0, 32'($signed($urandom_range(0, 1 << 28)) - (1 << 27))});
    write_reg(cev_tb_pkg::REG_STEPS, 47'($urandom_range(0, 8)));
    write_reg(cev_tb_pkg::REG_PATHS, ($urandom_range(9) == 0) ? 47'hFFFF_FFFF
                                     : 47'($urandom_range(0, 6)));
  endtask

  initial begin
    logic [15:0] z;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // directed: every beta code and both payoff kinds at extreme samples
    write_reg(cev_tb_pkg::REG_SPOT, 47'd100 << 24);
    write_reg(cev_tb_pkg::REG_STRIKE, 47'd100 << 24);
    write_reg(cev_tb_pkg::REG_DRIFT, 47'd1 << 20);
    write_reg(cev_tb_pkg::REG_DIFF, 47'd1 << 28);
    write_reg(cev_tb_pkg::REG_STEPS, 47'd1);
    write_reg(cev_tb_pkg::REG_PATHS, 47'd3);
    for (int b = 0; b < 4; b++) begin
      write_reg(cev_tb_pkg::REG_BETA, 47'(b));
      write_reg(cev_tb_pkg::REG_IS_PUT, 47'(b & 1));
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h0000);
      drain();
    end
    // price goes negative, then square root of a negative price
    write_reg(cev_tb_pkg::REG_BETA, 47'(cev_tb_pkg::BETA_SQRT));
    write_reg(cev_tb_pkg::REG_SPOT, ONE_Q24);
    write_reg(cev_tb_pkg::REG_DIFF, 47'h0_8000_0000);
    write_reg(cev_tb_pkg::REG_STEPS, 47'd2);
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);
    drain();
    // price and the squared-payoff sum saturate, payoff at its maximum
    write_reg(cev_tb_pkg::REG_SPOT, {47{1'b1}});
    write_reg(cev_tb_pkg::REG_STRIKE, '0);
    write_reg(cev_tb_pkg::REG_IS_PUT, 47'd0);
    write_reg(cev_tb_pkg::REG_BETA, 47'(cev_tb_pkg::BETA_SQUARE));
    write_reg(cev_tb_pkg::REG_DRIFT, 47'h0_7FFF_FFFF);
    write_reg(cev_tb_pkg::REG_DIFF, '0);
    write_reg(cev_tb_pkg::REG_STEPS, 47'd1);
    write_reg(cev_tb_pkg::REG_PATHS, 47'd4);
    repeat (4) send_sample(16'h1234);
    drain();
    // zero steps and zero paths act as one
    write_reg(cev_tb_pkg::REG_BETA, 47'(cev_tb_pkg::BETA_ONE));
    write_reg(cev_tb_pkg::REG_SPOT, 47'd100 << 24);
    write_reg(cev_tb_pkg::REG_DRIFT, '0);
    write_reg(cev_tb_pkg::REG_STEPS, '0);
    write_reg(cev_tb_pkg::REG_PATHS, '0);
    send_sample(16'h0800);
    drain();
    // limits lowered mid-path and mid-run
    write_reg(cev_tb_pkg::REG_STEPS, 47'hFFFF);
    write_reg(cev_tb_pkg::REG_PATHS, 47'hFFFF_FFFF);
    repeat (3) send_sample(16'($urandom));
    drain();
    write_reg(cev_tb_pkg::REG_STEPS, 47'd2);
    send_sample(16'($urandom));
    send_sample(16'($urandom));
    send_sample(16'($urandom));
    drain();
    write_reg(cev_tb_pkg::REG_PATHS, 47'd1);
    send_sample(16'($urandom));
    send_sample(16'($urandom));
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      tx_idle = (mode == 0) ? 25 : ((mode == 1) ? 87 : 0);
      rx_idle = (mode == 0) ? 87 : ((mode == 1) ? 25 : 0);
      for (int ph = 0; ph < 6; ph++) begin
        random_setup();
        for (int i = 0; i < 110; i++) begin
          z = 16'($urandom);
          if ($urandom_range(3) == 0) z = 16'($signed(z) >>> 3);
          send_sample(z);
          if (i == 55 && ph == 2) drain();
        end
        drain();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
